@@ design/fccm_pkg.sv @@
// Package for the FAT cluster chain manager: payload structs, codes and the
// command and status groups between controller and datapath.
// Depends on nothing; every other file of the block uses it.
package fccm_pkg;

   // Table geometry and register reset values.
   localparam int unsigned MAX_CLUSTERS_DEFAULT = 4096;
   localparam logic [12:0] CLUSTER_COUNT_RESET  = 13'd4096;
   localparam logic [23:0] DATA_START_RESET     = 24'd0;
   localparam logic [12:0] NEXT_FIT_RESET       = 13'd2;
   localparam logic [12:0] EOC_MARK             = 13'h1FFF;

   // Request codes.
   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_GET   = 2'd2;
   localparam logic [1:0] REQ_PUT   = 2'd3;

   // Status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_CLUSTER_COUNT = 1'b0;
   localparam logic CSR_DATA_START    = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [12:0] cluster;
      logic [12:0] prev_cluster;
      logic [12:0] write_value;
   } fccm_req_type;

   typedef struct packed {
      logic [12:0] result_cluster;
      logic [23:0] sector_number;
      logic [1:0]  status;
   } fccm_rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_LINK,
      S_MARK,
      S_WALK_RD,
      S_WALK_CLR,
      S_GET_WAIT
   } fccm_state_type;

   typedef enum logic [2:0] {
      MEM_NONE,
      MEM_CLEAR,
      MEM_PUT,
      MEM_FREE_PREV,
      MEM_LINK,
      MEM_MARK,
      MEM_WALK_CLR
   } fccm_mem_op_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_REQ,
      RD_SCAN,
      RD_WALK
   } fccm_rd_op_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_INVALID,
      RSP_PUT,
      RSP_GET,
      RSP_ALLOC,
      RSP_FULL,
      RSP_FREE
   } fccm_rsp_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              accept;
      fccm_mem_op_type   mem_op;
      fccm_rd_op_type    rd_op;
      logic              scan_init;
      logic              scan_step;
      logic              free_init;
      logic              walk_step;
      fccm_rsp_kind_type rsp_kind;
   } fccm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic req_invalid;
      logic scan_found;
      logic scan_exhausted;
      logic walk_stop;
   } fccm_stat_type;

endpackage

@@ design/fccm_ctrl.sv @@
// Controller of the FAT cluster chain manager: sequences the clearing pass,
// the allocate search, the chain walk and single entry accesses.
// Depends on fccm_pkg.
module fccm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_kind,
   input  fccm_pkg::fccm_stat_type stat,
   output logic                   busy,
   output fccm_pkg::fccm_cmd_type cmd
);

   fccm_pkg::fccm_state_type state_ff, state_in;

   // State register; reset starts the table clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fccm_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != fccm_pkg::S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.mem_op    = fccm_pkg::MEM_NONE;
      cmd.rd_op     = fccm_pkg::RD_NONE;
      cmd.rsp_kind  = fccm_pkg::RSP_NONE;
      case (state_ff)
         fccm_pkg::S_CLEAR: begin
            cmd.mem_op = fccm_pkg::MEM_CLEAR;
            if (stat.clr_last) begin
               state_in = fccm_pkg::S_IDLE;
            end
         end
         fccm_pkg::S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (stat.req_invalid) begin
                  cmd.rsp_kind = fccm_pkg::RSP_INVALID;
               end else begin
                  case (req_kind)
                     fccm_pkg::REQ_ALLOC: begin
                        cmd.scan_init = 1'b1;
                        state_in      = fccm_pkg::S_SCAN;
                     end
                     fccm_pkg::REQ_FREE: begin
                        cmd.free_init = 1'b1;
                        cmd.mem_op    = fccm_pkg::MEM_FREE_PREV;
                        state_in      = fccm_pkg::S_WALK_RD;
                     end
                     fccm_pkg::REQ_GET: begin
                        cmd.rd_op = fccm_pkg::RD_REQ;
                        state_in  = fccm_pkg::S_GET_WAIT;
                     end
                     default: begin
                        cmd.mem_op   = fccm_pkg::MEM_PUT;
                        cmd.rsp_kind = fccm_pkg::RSP_PUT;
                     end
                  endcase
               end
            end
         end
         fccm_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.rd_op     = fccm_pkg::RD_SCAN;
            if (stat.scan_found) begin
               state_in = fccm_pkg::S_LINK;
            end else if (stat.scan_exhausted) begin
               cmd.rsp_kind = fccm_pkg::RSP_FULL;
               state_in     = fccm_pkg::S_IDLE;
            end
         end
         fccm_pkg::S_LINK: begin
            cmd.mem_op = fccm_pkg::MEM_LINK;
            state_in   = fccm_pkg::S_MARK;
         end
         fccm_pkg::S_MARK: begin
            cmd.mem_op   = fccm_pkg::MEM_MARK;
            cmd.rsp_kind = fccm_pkg::RSP_ALLOC;
            state_in     = fccm_pkg::S_IDLE;
         end
         fccm_pkg::S_WALK_RD: begin
            cmd.rd_op = fccm_pkg::RD_WALK;
            state_in  = fccm_pkg::S_WALK_CLR;
         end
         fccm_pkg::S_WALK_CLR: begin
            cmd.mem_op    = fccm_pkg::MEM_WALK_CLR;
            cmd.walk_step = 1'b1;
            if (stat.walk_stop) begin
               cmd.rsp_kind = fccm_pkg::RSP_FREE;
               state_in     = fccm_pkg::S_IDLE;
            end else begin
               state_in = fccm_pkg::S_WALK_RD;
            end
         end
         fccm_pkg::S_GET_WAIT: begin
            cmd.rsp_kind = fccm_pkg::RSP_GET;
            state_in     = fccm_pkg::S_IDLE;
         end
         default: begin
            state_in = fccm_pkg::S_IDLE;
         end
      endcase
   end

endmodule

@@ design/fccm_dpath.sv @@
// Datapath of the FAT cluster chain manager: link table memory, next-fit
// pointer, configuration registers, search and walk registers, result register.
// Depends on fccm_pkg; driven by fccm_ctrl.
module fccm_dpath #(
   parameter int unsigned MAX_CLUSTERS = fccm_pkg::MAX_CLUSTERS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fccm_pkg::fccm_req_type req_data,
   input  fccm_pkg::fccm_cmd_type cmd,
   output fccm_pkg::fccm_stat_type stat,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [23:0]            csr_wdata,
   output logic                   rsp_valid,
   output fccm_pkg::fccm_rsp_type rsp_data
);

   localparam int unsigned ADDR_W = $clog2(MAX_CLUSTERS);
   localparam logic [ADDR_W-1:0] CLR_LAST_ADDR = ADDR_W'(MAX_CLUSTERS - 1);
   // Clusters are 13-bit numbers, so the usable count never exceeds 8191.
   localparam logic [12:0] N_CAP = (MAX_CLUSTERS > 8191) ? 13'd8191 : 13'(MAX_CLUSTERS);

   // Cluster number to table address.
   function automatic logic [ADDR_W-1:0] addr_of(input logic [12:0] c);
      logic [12:0] m;
      m = c - 13'd1;
      return ADDR_W'(m);
   endfunction

   logic [12:0] link_mem [MAX_CLUSTERS];
   logic [12:0] rd_data_ff;

   logic [12:0] cluster_count_ff, cluster_count_in;
   logic [23:0] data_start_ff, data_start_in;
   logic [12:0] next_fit_ff, next_fit_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [12:0] op_cluster_ff;
   logic [12:0] scan_ptr_ff, scan_ptr_in;
   logic [12:0] issue_cnt_ff, issue_cnt_in;
   logic [12:0] chk_clu_ff, chk_clu_in;
   logic        chk_vld_ff, chk_vld_in;
   logic [12:0] chk_cnt_ff, chk_cnt_in;
   logic [12:0] alloc_ff, alloc_in;
   logic [12:0] walk_cur_ff, walk_cur_in;
   logic [12:0] walk_cnt_ff, walk_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   fccm_pkg::fccm_rsp_type rsp_ff, rsp_in;

   logic [12:0] n_eff, n_m1;
   logic        c_ok, p_ok, nf_ok, nx_ok;
   logic        req_invalid;
   logic [12:0] scan_start, scan_wrap;
   logic        scan_issue;
   logic        wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [12:0] wr_data;
   logic [12:0] sec_cluster;
   logic [23:0] sector;

   // Effective cluster count and range checks.
   always_comb begin
      if (cluster_count_ff == 13'd0) begin
         n_eff = 13'd1;
      end else if (cluster_count_ff > N_CAP) begin
         n_eff = N_CAP;
      end else begin
         n_eff = cluster_count_ff;
      end
      n_m1  = n_eff - 13'd1;
      c_ok  = (req_data.cluster != 13'd0) && (req_data.cluster <= n_eff);
      p_ok  = (req_data.prev_cluster == 13'd0) || (req_data.prev_cluster <= n_eff);
      nf_ok = (next_fit_ff != 13'd0) && (next_fit_ff <= n_eff);
      nx_ok = (rd_data_ff != 13'd0) && (rd_data_ff <= n_eff);
   end

   // Validity of the request on the input ports.
   always_comb begin
      case (req_data.req_type)
         fccm_pkg::REQ_ALLOC: req_invalid = (req_data.cluster != 13'd0) && !c_ok;
         fccm_pkg::REQ_FREE:  req_invalid = !c_ok || !p_ok;
         default:             req_invalid = !c_ok;
      endcase
   end

   assign stat.req_invalid = req_invalid;

   // Search status: a check completes in the cycle after its read is issued.
   assign scan_start          = nf_ok ? next_fit_ff : 13'd1;
   assign scan_wrap           = (scan_ptr_ff >= n_eff) ? 13'd1 : scan_ptr_ff + 13'd1;
   assign scan_issue          = (issue_cnt_ff != n_eff);
   assign stat.scan_found     = chk_vld_ff && (rd_data_ff == 13'd0);
   assign stat.scan_exhausted = chk_vld_ff && (rd_data_ff != 13'd0) && (chk_cnt_ff == n_m1);
   assign stat.walk_stop      = (rd_data_ff == fccm_pkg::EOC_MARK) || !nx_ok
                                || (walk_cnt_ff == n_m1);
   assign stat.clr_last       = (clr_addr_ff == CLR_LAST_ADDR);

   // Table write port selection.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_of(walk_cur_ff);
      wr_data = 13'd0;
      case (cmd.mem_op)
         fccm_pkg::MEM_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
         end
         fccm_pkg::MEM_PUT: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(req_data.cluster);
            wr_data = req_data.write_value;
         end
         fccm_pkg::MEM_FREE_PREV: begin
            wr_en   = (req_data.prev_cluster != 13'd0);
            wr_addr = addr_of(req_data.prev_cluster);
            wr_data = fccm_pkg::EOC_MARK;
         end
         fccm_pkg::MEM_LINK: begin
            wr_en   = (op_cluster_ff != 13'd0);
            wr_addr = addr_of(op_cluster_ff);
            wr_data = alloc_ff;
         end
         fccm_pkg::MEM_MARK: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(alloc_ff);
            wr_data = fccm_pkg::EOC_MARK;
         end
         fccm_pkg::MEM_WALK_CLR: begin
            wr_en = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Table read port selection.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = addr_of(walk_cur_ff);
      case (cmd.rd_op)
         fccm_pkg::RD_REQ: begin
            rd_en   = 1'b1;
            rd_addr = addr_of(req_data.cluster);
         end
         fccm_pkg::RD_SCAN: begin
            rd_en   = scan_issue;
            rd_addr = addr_of(scan_ptr_ff);
         end
         fccm_pkg::RD_WALK: begin
            rd_en = 1'b1;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // Link table memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= link_mem[rd_addr];
      end
   end

   // Configuration writes.
   always_comb begin
      cluster_count_in = cluster_count_ff;
      data_start_in    = data_start_ff;
      if (csr_write) begin
         case (csr_index)
            fccm_pkg::CSR_CLUSTER_COUNT: cluster_count_in = csr_wdata[12:0];
            fccm_pkg::CSR_DATA_START:    data_start_in    = csr_wdata;
            default:                     data_start_in    = data_start_ff;
         endcase
      end
   end

   // Search and walk registers.
   always_comb begin
      scan_ptr_in  = scan_ptr_ff;
      issue_cnt_in = issue_cnt_ff;
      chk_clu_in   = chk_clu_ff;
      chk_vld_in   = chk_vld_ff;
      chk_cnt_in   = chk_cnt_ff;
      alloc_in     = alloc_ff;
      walk_cur_in  = walk_cur_ff;
      walk_cnt_in  = walk_cnt_ff;
      next_fit_in  = next_fit_ff;
      if (cmd.scan_init) begin
         scan_ptr_in  = scan_start;
         issue_cnt_in = 13'd0;
         chk_vld_in   = 1'b0;
         chk_cnt_in   = 13'd0;
      end
      if (cmd.scan_step) begin
         chk_vld_in = scan_issue;
         chk_clu_in = scan_ptr_ff;
         if (scan_issue) begin
            scan_ptr_in  = scan_wrap;
            issue_cnt_in = issue_cnt_ff + 13'd1;
         end
         if (chk_vld_ff) begin
            chk_cnt_in = chk_cnt_ff + 13'd1;
         end
         if (stat.scan_found) begin
            alloc_in = chk_clu_ff;
         end
      end
      if (cmd.free_init) begin
         next_fit_in = req_data.cluster;
         walk_cur_in = req_data.cluster;
         walk_cnt_in = 13'd0;
      end
      if (cmd.walk_step) begin
         walk_cur_in = rd_data_ff;
         walk_cnt_in = walk_cnt_ff + 13'd1;
      end
      if (cmd.mem_op == fccm_pkg::MEM_MARK) begin
         next_fit_in = alloc_ff;
      end
   end

   // Result formation.
   always_comb begin
      sec_cluster = op_cluster_ff;
      if (cmd.rsp_kind == fccm_pkg::RSP_PUT) begin
         sec_cluster = req_data.cluster;
      end else if (cmd.rsp_kind == fccm_pkg::RSP_ALLOC) begin
         sec_cluster = alloc_ff;
      end
      sector       = data_start_ff + {11'd0, sec_cluster} - 24'd1;
      rsp_valid_in = (cmd.rsp_kind != fccm_pkg::RSP_NONE);
      rsp_in       = '0;
      case (cmd.rsp_kind)
         fccm_pkg::RSP_INVALID: rsp_in.status = fccm_pkg::STATUS_INVALID;
         fccm_pkg::RSP_FULL:    rsp_in.status = fccm_pkg::STATUS_FULL;
         fccm_pkg::RSP_PUT,
         fccm_pkg::RSP_FREE: begin
            rsp_in.sector_number = sector;
         end
         fccm_pkg::RSP_GET: begin
            rsp_in.result_cluster = rd_data_ff;
            rsp_in.sector_number  = sector;
         end
         fccm_pkg::RSP_ALLOC: begin
            rsp_in.result_cluster = alloc_ff;
            rsp_in.sector_number  = sector;
         end
         default: rsp_in = '0;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_count_ff <= fccm_pkg::CLUSTER_COUNT_RESET;
         data_start_ff    <= fccm_pkg::DATA_START_RESET;
         next_fit_ff      <= fccm_pkg::NEXT_FIT_RESET;
         clr_addr_ff      <= '0;
         chk_vld_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cluster_count_ff <= cluster_count_in;
         data_start_ff    <= data_start_in;
         next_fit_ff      <= next_fit_in;
         chk_vld_ff       <= chk_vld_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (cmd.mem_op == fccm_pkg::MEM_CLEAR && !stat.clr_last) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_cluster_ff <= req_data.cluster;
      end
      scan_ptr_ff  <= scan_ptr_in;
      issue_cnt_ff <= issue_cnt_in;
      chk_clu_ff   <= chk_clu_in;
      chk_cnt_ff   <= chk_cnt_in;
      alloc_ff     <= alloc_in;
      walk_cur_ff  <= walk_cur_in;
      walk_cnt_ff  <= walk_cnt_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/fat_cluster_chain_manager.sv @@
// Top level of the FAT cluster chain manager: joins controller and datapath.
// Depends on fccm_pkg, fccm_ctrl and fccm_dpath.
//
// After reset the block clears its link table, one entry a cycle, with busy
// high; configuration writes are taken at any time. A request is taken when
// start is high and busy is low, and its result appears on rsp_data for one
// cycle with rsp_valid high; the receiver cannot hold it off. Put and any
// rejected request answer in the next cycle and leave busy low, so one can be
// issued every cycle. Get reads the table when it is taken and answers from
// the GET_WAIT state, as the table read is registered. Allocate searches from
// the next-fit pointer, reading one table entry per cycle, then links and
// marks the new entry in the LINK and MARK states. Free reads each entry of
// the chain and then clears it through the single table write port.
module fat_cluster_chain_manager #(
   parameter int unsigned MAX_CLUSTERS = fccm_pkg::MAX_CLUSTERS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  fccm_pkg::fccm_req_type req_data,
   output logic                   rsp_valid,
   output fccm_pkg::fccm_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [23:0]            csr_wdata
);

   fccm_pkg::fccm_cmd_type  cmd;
   fccm_pkg::fccm_stat_type stat;

   // Configuration registers always accept a transaction.
   assign csr_ready = 1'b1;

   fccm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_data.req_type),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   fccm_dpath #(
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // A put transaction always answers in the next cycle.
   a_put_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.req_type == fccm_pkg::REQ_PUT) |=> rsp_valid)
      else $error("put transaction did not answer in the next cycle");

   // A result only follows an accepted transaction or work in progress.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result without a transaction");

   // A failed transaction carries no cluster and no sector.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != fccm_pkg::STATUS_OK)
         |-> (rsp_data.result_cluster == 13'd0 && rsp_data.sector_number == 24'd0))
      else $error("failed transaction with nonzero payload");

   // The controller never accepts new work while the table is being cleared.
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_op == fccm_pkg::MEM_CLEAR) |-> (busy && !cmd.accept))
      else $error("transaction accepted during clearing pass");

endmodule
